// ----- rtl/core/rfc_pkg.sv -----
// rfc_pkg: shared constants and types for the rfc lookup block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rfc_pkg;
   localparam int TABLE_DEPTH_DEF = 65536;
   localparam int MAX_CLASSES_DEF = 4096;
   localparam int MAX_RULES_DEF   = 4096;
   localparam int CHUNK_DEPTH     = 65536;
   localparam int CLS_W           = 12;
   localparam int CNT_W           = 13;
   localparam int FIN_W           = 13;

   localparam logic [3:0] SEL_P1_FIRST = 4'd7;
   localparam logic [3:0] SEL_P1_LAST  = 4'd9;
   localparam logic [3:0] SEL_P2       = 4'd10;
   localparam logic [3:0] SEL_P3       = 4'd11;
   localparam logic [3:0] SEL_FINAL    = 4'd12;

   localparam logic [2:0] REG_NUM_PHASES = 3'd0;
   localparam logic [2:0] REG_SRC_HI     = 3'd1;
   localparam logic [2:0] REG_DST_HI     = 3'd2;
   localparam logic [2:0] REG_SPORT      = 3'd3;
   localparam logic [2:0] REG_DPORT      = 3'd4;
   localparam logic [2:0] REG_DST_PAIR   = 3'd5;
   localparam logic [2:0] REG_PROTO_PORT = 3'd6;
   localparam logic [2:0] REG_ADDR_PAIR  = 3'd7;

   typedef struct packed {
      logic [2:0]       num_phases;
      logic [CNT_W-1:0] src_hi;
      logic [CNT_W-1:0] dst_hi;
      logic [CNT_W-1:0] sport;
      logic [CNT_W-1:0] dport;
      logic [CNT_W-1:0] dst_pair;
      logic [CNT_W-1:0] proto_port;
      logic [CNT_W-1:0] addr_pair;
   } cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic        wr;
      logic [3:0]  sel;
      logic [15:0] idx;
      logic [12:0] data;
      logic [15:0] k0, k1, k2, k3, k4, k5, k6;
   } item_type;
endpackage
`default_nettype wire

// ----- rtl/core/rfc_ram.sv -----
// rfc_ram: generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module rfc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire                      re,
   input  wire [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/rfc_front.sv -----
// rfc_front: accepts requests, splits headers into chunks, decodes writes
// depends on rfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module rfc_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire               req_mode,
   input  wire [31:0]        req_src_addr,
   input  wire [31:0]        req_dst_addr,
   input  wire [7:0]         req_protocol,
   input  wire [15:0]        req_src_port,
   input  wire [15:0]        req_dst_port,
   input  wire [3:0]         req_table_select,
   input  wire [15:0]        req_table_index,
   input  wire [12:0]        req_table_data,
   output logic              q_valid,
   input  wire               q_ready,
   output rfc_pkg::item_type q_item
);
   // two entry queue between front and back
   rfc_pkg::item_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wp_ff, wp_in;
   rfc_pkg::item_type it;
   logic push, pop;

   always_comb begin
      it.wr   = req_mode;
      it.sel  = req_table_select;
      it.idx  = req_table_index;
      it.data = req_table_data;
      it.k0   = req_src_addr[15:0];
      it.k1   = req_src_addr[31:16];
      it.k2   = req_dst_addr[15:0];
      it.k3   = req_dst_addr[31:16];
      it.k4   = {8'd0, req_protocol};
      it.k5   = req_src_port;
      it.k6   = req_dst_port;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_item    = buf_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wp_in  = wp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wp_ff  <= wp_in;
      end
      if (push) buf_ff[wp_ff] <= it;
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop && cnt_ff != 2'd2 |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count step");
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ----- rtl/core/rfc_back.sv -----
// rfc_back: pipelined table lookup through all rfc phases and table writes
// depends on rfc_pkg, rfc_ram
`timescale 1ns / 1ps
`default_nettype none
module rfc_back #(
   parameter int TABLE_DEPTH = rfc_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_CLASSES = rfc_pkg::MAX_CLASSES_DEF,
   parameter int MAX_RULES   = rfc_pkg::MAX_RULES_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  rfc_pkg::cfg_type  cfg,
   input  wire               q_valid,
   output logic              q_ready,
   input  rfc_pkg::item_type q_item,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic              rsp_matched,
   output logic [11:0]       rsp_rule_id,
   output logic              rsp_index_error
);
   localparam int TW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(MAX_CLASSES);
   localparam int NS = 12;
   localparam int W  = rfc_pkg::CLS_W;

   // pipeline advances when the output slot is free or being taken
   logic adv;
   logic [NS-1:0] v_ff;
   assign adv     = !rsp_valid || rsp_ready;
   assign q_ready = adv;

   logic acc;
   assign acc = q_valid && adv;
   logic cwr;
   assign cwr = acc && q_item.wr;

   // stage 1: chunk reads
   logic [W-1:0] ch [7];
   logic [15:0] key [7];
   assign key[0] = q_item.k0; assign key[1] = q_item.k1; assign key[2] = q_item.k2;
   assign key[3] = q_item.k3; assign key[4] = q_item.k4; assign key[5] = q_item.k5;
   assign key[6] = q_item.k6;
   for (genvar t = 0; t < 7; t++) begin : g_chunk
      rfc_ram #(.WIDTH(W), .DEPTH(rfc_pkg::CHUNK_DEPTH)) u_ram (
         .clock(clock),
         .we(cwr && q_item.sel == 4'(t)), .waddr(q_item.idx), .wdata(q_item.data[W-1:0]),
         .re(adv), .raddr(key[t]), .rdata(ch[t]));
   end

   // write request travels along the pipe for later tables
   logic        wv_ff [NS];
   logic [3:0]  ws_ff [NS-1];
   logic [15:0] wi_ff [NS-1];
   logic [12:0] wd_ff [NS-1];
   logic        er_ff [3:9];

   // stage 2: products for phase 1
   logic [24:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic [W-1:0] g6_ff, b1_ff, d3_ff;
   // stage 3: sums and partial
   logic [26:0] i0_ff, i1_ff;
   logic [37:0] p2_ff;
   logic [26:0] s2_ff;
   // stage 4: index 2, indexes 0 and 1 held to match
   logic [39:0] i2_ff;
   logic [26:0] i0b_ff, i1b_ff;
   // stage 5: phase1 read data
   logic [W-1:0] a1, c1, e1;
   // stage 6: phase 2 products
   logic [24:0] n0_ff, n1_ff, n2_ff;
   logic [W-1:0] e2_ff, c2_ff;
   // stage 7: three-way product and sums
   logic [37:0] n3_ff;
   logic [26:0] n4_ff, x4_ff;
   logic [W-1:0] e3_ff;
   // stage 8: phase 2 index, read
   logic [39:0] x3_ff;
   logic [W-1:0] p2d, p3d, fin;
   logic [W-1:0] e4_ff;
   logic three_ff [NS-2];

   logic wr_p2, wr_p3, wr_fin;
   logic [TW-1:0] p1_ra [3];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], acc};
   end

   // tables beyond phase 0 are written when the write request reaches the
   // lookup stage that reads them, so order with lookups stays intact
   always_ff @(posedge clock) begin
      if (adv) begin
         wv_ff[0] <= cwr; ws_ff[0] <= q_item.sel;
         wi_ff[0] <= q_item.idx; wd_ff[0] <= q_item.data;
         three_ff[0] <= (cfg.num_phases == 3'd3);
         for (int s = 1; s < NS; s++) wv_ff[s] <= wv_ff[s-1];
         for (int s = 1; s < NS-1; s++) begin
            ws_ff[s] <= ws_ff[s-1];
            wi_ff[s] <= wi_ff[s-1]; wd_ff[s] <= wd_ff[s-1];
         end
         for (int s = 1; s < NS-2; s++) three_ff[s] <= three_ff[s-1];
         // stage 1
         m0_ff <= 25'(ch[0]) * 25'(cfg.src_hi);
         m1_ff <= 25'(ch[2]) * 25'(cfg.dst_hi);
         m2_ff <= 25'(ch[4]) * 25'(cfg.sport);
         m3_ff <= 25'(ch[5]) * 25'(cfg.dport);
         g6_ff <= ch[6]; b1_ff <= ch[1]; d3_ff <= ch[3];
         // stage 2
         i0_ff <= 27'(m0_ff) + 27'(b1_ff);
         i1_ff <= 27'(m1_ff) + 27'(d3_ff);
         p2_ff <= 38'(m2_ff) * 38'(cfg.dport);
         s2_ff <= 27'(m3_ff) + 27'(g6_ff);
         // stage 3
         i2_ff  <= 40'(p2_ff) + 40'(s2_ff);
         i0b_ff <= i0_ff;
         i1b_ff <= i1_ff;
         er_ff[3] <= (i0_ff >= 27'(TABLE_DEPTH)) || (i1_ff >= 27'(TABLE_DEPTH))
                   || (40'(p2_ff) + 40'(s2_ff) >= 40'(TABLE_DEPTH));
         // stage 4: phase 1 read issued, stage 5 data
         er_ff[4] <= er_ff[3];
         er_ff[5] <= er_ff[4];
         // stage 5
         n0_ff <= 25'(a1) * 25'(cfg.dst_pair);
         n1_ff <= 25'(c1) * 25'(cfg.proto_port);
         n2_ff <= 25'(a1) * 25'(cfg.dst_pair);
         e2_ff <= e1; c2_ff <= c1;
         er_ff[6] <= er_ff[5];
         // stage 6
         n3_ff <= 38'(n0_ff) * 38'(cfg.proto_port);
         n4_ff <= 27'(n1_ff) + 27'(e2_ff);
         x4_ff <= 27'(n2_ff) + 27'(c2_ff);
         e3_ff <= e2_ff;
         er_ff[7] <= er_ff[6] || (three_ff[6] ?
            (40'(n3_ff) + 40'(n4_ff) >= 40'(TABLE_DEPTH)) : (x4_ff >= 27'(TABLE_DEPTH)));
         // stage 7
         x3_ff <= 40'(n3_ff) + 40'(n4_ff);
         e4_ff <= e3_ff;
         er_ff[8] <= er_ff[7];
         // stage 8: phase 2 read, data at 9
         er_ff[9] <= er_ff[8];
      end
   end

   // stage 4 phase1 read addresses
   always_comb begin
      p1_ra[0] = i0b_ff[TW-1:0];
      p1_ra[1] = i1b_ff[TW-1:0];
      p1_ra[2] = i2_ff[TW-1:0];
   end
   logic [W-1:0] p1d [3];
   for (genvar t = 0; t < 3; t++) begin : g_p1
      rfc_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_ram (
         .clock(clock),
         .we(adv && wv_ff[3] && ws_ff[3] == rfc_pkg::SEL_P1_FIRST + 4'(t)
             && 32'(wi_ff[3]) < 32'(TABLE_DEPTH)),
         .waddr(TW'(wi_ff[3])), .wdata(wd_ff[3][W-1:0]),
         .re(adv), .raddr(p1_ra[t]), .rdata(p1d[t]));
   end
   assign a1 = p1d[0]; assign c1 = p1d[1]; assign e1 = p1d[2];

   // phase 2 read issued at stage 8
   logic [TW-1:0] p2_ra;
   logic [26:0] x4b_ff;
   always_ff @(posedge clock) if (adv) begin
      x4b_ff <= x4_ff;
   end
   assign p2_ra = three_ff[7] ? x3_ff[TW-1:0] : x4b_ff[TW-1:0];
   assign wr_p2 = adv && wv_ff[7] && ws_ff[7] == rfc_pkg::SEL_P2
                  && 32'(wi_ff[7]) < 32'(TABLE_DEPTH);
   rfc_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_p2 (
      .clock(clock), .we(wr_p2), .waddr(TW'(wi_ff[7])), .wdata(wd_ff[7][W-1:0]),
      .re(adv), .raddr(p2_ra), .rdata(p2d));

   // stage 9: phase 3 index
   logic [24:0] y_ff;
   logic [W-1:0] p2d_ff, e5_ff;
   logic [26:0] y3;
   always_ff @(posedge clock) if (adv) begin
      e5_ff  <= e4_ff;
      y_ff   <= 25'(e5_ff) * 25'(cfg.addr_pair);
      p2d_ff <= p2d;
   end
   assign y3 = 27'(y_ff) + 27'(p2d_ff);
   assign wr_p3 = adv && wv_ff[9] && ws_ff[9] == rfc_pkg::SEL_P3
                  && 32'(wi_ff[9]) < 32'(TABLE_DEPTH);
   rfc_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_p3 (
      .clock(clock), .we(wr_p3), .waddr(TW'(wi_ff[9])), .wdata(wd_ff[9][W-1:0]),
      .re(adv), .raddr(y3[TW-1:0]), .rdata(p3d));

   logic e10_ff, e11_ff, three10_ff;
   logic [W-1:0] p2d2_ff;
   logic [31:0] fin_cls;
   assign fin = three10_ff ? p2d2_ff : p3d;
   assign fin_cls = 32'(fin);
   always_ff @(posedge clock) if (adv) begin
      e10_ff     <= er_ff[9] || (!three_ff[9] && y3 >= 27'(TABLE_DEPTH));
      three10_ff <= three_ff[9];
      p2d2_ff    <= p2d_ff;
      e11_ff     <= e10_ff || (fin_cls >= 32'(MAX_CLASSES));
   end

   logic [rfc_pkg::FIN_W-1:0] fdat;
   assign wr_fin = adv && wv_ff[10] && ws_ff[10] == rfc_pkg::SEL_FINAL
                   && 32'(wi_ff[10]) < 32'(MAX_CLASSES);
   rfc_ram #(.WIDTH(rfc_pkg::FIN_W), .DEPTH(MAX_CLASSES)) u_fin (
      .clock(clock), .we(wr_fin), .waddr(CW'(wi_ff[10])), .wdata(wd_ff[10]),
      .re(adv), .raddr(CW'(fin)), .rdata(fdat));

   // output register
   logic lk_last;
   assign lk_last = v_ff[NS-1] && !wv_ff[NS-1];
   logic bad;
   assign bad = e11_ff || (17'(fdat) > 17'(MAX_RULES));
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= lk_last;
      if (adv) begin
         rsp_index_error <= bad;
         rsp_matched     <= !bad && fdat != '0;
         rsp_rule_id     <= (!bad && fdat != '0) ? 12'(fdat - 13'd1) : 12'd0;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_mexcl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_matched && rsp_index_error)) else $error("match with error");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff)) else $error("pipe moved while stalled");
endmodule
`default_nettype wire

// ----- rtl/core/rfc_packet_classify_lookup_top.sv -----
// rfc_packet_classify_lookup_top: rfc lookup top level with csr block
// depends on rfc_pkg, rfc_front, rfc_back
//
//  channel | handshake           | carries
//  req     | req_valid/req_ready | classify header or table write
//  rsp     | rsp_valid/rsp_ready | match, rule id, index error
//  csr     | apb psel/penable    | eight lookup registers
//
// one request per cycle unless the back pipeline stalls on rsp_ready; a lookup result passes
// through the 12-stage table pipeline and then the output register
// writes give no result; back pipeline stalls as a whole on rsp_ready
// two-entry queue decouples front from back; reset is synchronous, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module rfc_packet_classify_lookup_top #(
   parameter int TABLE_DEPTH = rfc_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_CLASSES = rfc_pkg::MAX_CLASSES_DEF,
   parameter int MAX_RULES   = rfc_pkg::MAX_RULES_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_mode,
   input  wire [31:0]  req_src_addr,
   input  wire [31:0]  req_dst_addr,
   input  wire [7:0]   req_protocol,
   input  wire [15:0]  req_src_port,
   input  wire [15:0]  req_dst_port,
   input  wire [3:0]   req_table_select,
   input  wire [15:0]  req_table_index,
   input  wire [12:0]  req_table_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_matched,
   output logic [11:0] rsp_rule_id,
   output logic        rsp_index_error,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire [4:0]   csr_paddr,
   input  wire [31:0]  csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   rfc_pkg::cfg_type cfg_ff;
   logic [2:0] ra;
   logic wr;
   assign ra = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_phases <= 3'd4;
         cfg_ff.src_hi <= 13'd1; cfg_ff.dst_hi <= 13'd1;
         cfg_ff.sport <= 13'd1; cfg_ff.dport <= 13'd1;
         cfg_ff.dst_pair <= 13'd1; cfg_ff.proto_port <= 13'd1;
         cfg_ff.addr_pair <= 13'd1;
      end else if (wr) begin
         case (ra)
            rfc_pkg::REG_NUM_PHASES: cfg_ff.num_phases <= csr_pwdata[2:0];
            rfc_pkg::REG_SRC_HI:     cfg_ff.src_hi     <= csr_pwdata[12:0];
            rfc_pkg::REG_DST_HI:     cfg_ff.dst_hi     <= csr_pwdata[12:0];
            rfc_pkg::REG_SPORT:      cfg_ff.sport      <= csr_pwdata[12:0];
            rfc_pkg::REG_DPORT:      cfg_ff.dport      <= csr_pwdata[12:0];
            rfc_pkg::REG_DST_PAIR:   cfg_ff.dst_pair   <= csr_pwdata[12:0];
            rfc_pkg::REG_PROTO_PORT: cfg_ff.proto_port <= csr_pwdata[12:0];
            rfc_pkg::REG_ADDR_PAIR:  cfg_ff.addr_pair  <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ra)
         rfc_pkg::REG_NUM_PHASES: csr_prdata = {29'd0, cfg_ff.num_phases};
         rfc_pkg::REG_SRC_HI:     csr_prdata = {19'd0, cfg_ff.src_hi};
         rfc_pkg::REG_DST_HI:     csr_prdata = {19'd0, cfg_ff.dst_hi};
         rfc_pkg::REG_SPORT:      csr_prdata = {19'd0, cfg_ff.sport};
         rfc_pkg::REG_DPORT:      csr_prdata = {19'd0, cfg_ff.dport};
         rfc_pkg::REG_DST_PAIR:   csr_prdata = {19'd0, cfg_ff.dst_pair};
         rfc_pkg::REG_PROTO_PORT: csr_prdata = {19'd0, cfg_ff.proto_port};
         rfc_pkg::REG_ADDR_PAIR:  csr_prdata = {19'd0, cfg_ff.addr_pair};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   logic q_valid, q_ready;
   rfc_pkg::item_type q_item;

   rfc_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_src_addr(req_src_addr), .req_dst_addr(req_dst_addr),
      .req_protocol(req_protocol), .req_src_port(req_src_port),
      .req_dst_port(req_dst_port), .req_table_select(req_table_select),
      .req_table_index(req_table_index), .req_table_data(req_table_data),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

   rfc_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CLASSES(MAX_CLASSES), .MAX_RULES(MAX_RULES))
   u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_matched(rsp_matched),
      .rsp_rule_id(rsp_rule_id), .rsp_index_error(rsp_index_error));
endmodule
`default_nettype wire

// ----- sim/tb_rfc_packet_classify_lookup_top.sv -----
// tb_rfc_packet_classify_lookup_top: self-checking bench for the rfc lookup top level
// loads tables through write requests, classifies headers and checks each verdict
// depends on rfc_pkg and rfc_packet_classify_lookup_top
`timescale 1ns / 1ps
module tb_rfc_packet_classify_lookup_top;
   localparam longint unsigned DEPTH = rfc_pkg::TABLE_DEPTH_DEF;
   localparam int SEL_SRC_LO = 0, SEL_SRC_HI = 1, SEL_DST_LO = 2, SEL_DST_HI = 3;
   localparam int SEL_PROTO = 4, SEL_SPORT = 5, SEL_DPORT = 6;
   localparam int SEL_SRC_PAIR = 7, SEL_DST_PAIR = 8, SEL_PP = 9;
   localparam bit MODE_CLASSIFY = 1'b0, MODE_WRITE = 1'b1;

   typedef struct {
      bit        mode;
      bit [31:0] src, dst;
      bit [7:0]  proto;
      bit [15:0] sport, dport;
      bit [3:0]  sel;
      bit [15:0] idx;
      bit [12:0] data;
   } request_type;

   typedef struct {
      bit        matched;
      bit [11:0] rule_id;
      bit        index_error;
   } verdict_type;

   class rfc_scoreboard;
      int unsigned entries[int];
      longint unsigned cfg[8];
      verdict_type pending[$];
      int errors, lookups, hits, idx_errors;
      int miss_sel, miss_idx;

      function new();
         cfg[rfc_pkg::REG_NUM_PHASES] = 4;
         for (int i = 1; i < 8; i++) cfg[i] = 1;
      endfunction

      function void set_reg(int r, longint unsigned v);
         cfg[r] = (r == rfc_pkg::REG_NUM_PHASES) ? (v & 7) : (v & 13'h1FFF);
      endfunction

      function longint unsigned rd(int s, longint unsigned i);
         if (!entries.exists(s * 65536 + int'(i))) begin
            if (miss_sel < 0) begin
               miss_sel = s;
               miss_idx = int'(i);
            end
            return 0;
         end
         return entries[s * 65536 + int'(i)];
      endfunction

      // walks the lookup network; miss_sel >= 0 names the first unwritten entry
      function void classify(request_type r, output verdict_type o);
         longint unsigned a, b, c, d, e, f, g, x, cls, ent;
         miss_sel = -1;
         o = '{0, 0, 1};
         a = rd(SEL_SRC_LO, r.src[15:0]);
         b = rd(SEL_SRC_HI, r.src[31:16]);
         c = rd(SEL_DST_LO, r.dst[15:0]);
         d = rd(SEL_DST_HI, r.dst[31:16]);
         e = rd(SEL_PROTO, r.proto);
         f = rd(SEL_SPORT, r.sport);
         g = rd(SEL_DPORT, r.dport);
         if (miss_sel >= 0) return;
         x = a * cfg[rfc_pkg::REG_SRC_HI] + b;
         if (x >= DEPTH) return;
         a = rd(SEL_SRC_PAIR, x);
         if (miss_sel >= 0) return;
         x = c * cfg[rfc_pkg::REG_DST_HI] + d;
         if (x >= DEPTH) return;
         c = rd(SEL_DST_PAIR, x);
         if (miss_sel >= 0) return;
         x = e * cfg[rfc_pkg::REG_SPORT] * cfg[rfc_pkg::REG_DPORT]
             + f * cfg[rfc_pkg::REG_DPORT] + g;
         if (x >= DEPTH) return;
         e = rd(SEL_PP, x);
         if (miss_sel >= 0) return;
         if (cfg[rfc_pkg::REG_NUM_PHASES] == 3) begin
            x = a * cfg[rfc_pkg::REG_DST_PAIR] * cfg[rfc_pkg::REG_PROTO_PORT]
                + c * cfg[rfc_pkg::REG_PROTO_PORT] + e;
            if (x >= DEPTH) return;
            cls = rd(rfc_pkg::SEL_P2, x);
         end else begin
            x = a * cfg[rfc_pkg::REG_DST_PAIR] + c;
            if (x >= DEPTH) return;
            a = rd(rfc_pkg::SEL_P2, x);
            if (miss_sel >= 0) return;
            x = e * cfg[rfc_pkg::REG_ADDR_PAIR] + a;
            if (x >= DEPTH) return;
            cls = rd(rfc_pkg::SEL_P3, x);
         end
         if (miss_sel >= 0) return;
         if (cls >= rfc_pkg::MAX_CLASSES_DEF) return;
         ent = rd(rfc_pkg::SEL_FINAL, cls);
         if (miss_sel >= 0 || ent > rfc_pkg::MAX_RULES_DEF) return;
         o.index_error = 0;
         if (ent != 0) begin
            o.matched = 1;
            o.rule_id = 12'((ent - 1) & 12'hFFF);
         end
      endfunction

      function void note(request_type r);
         verdict_type v;
         if (r.mode == MODE_WRITE) begin
            if (r.sel < rfc_pkg::SEL_FINAL) entries[r.sel * 65536 + r.idx] = r.data & 12'hFFF;
            else if (r.sel == rfc_pkg::SEL_FINAL && r.idx < rfc_pkg::MAX_CLASSES_DEF)
               entries[r.sel * 65536 + r.idx] = r.data;
            return;
         end
         classify(r, v);
         if (miss_sel >= 0) begin
            $error("lookup reads unwritten entry table %0d index %0d", miss_sel, miss_idx);
            errors++;
         end
         lookups++;
         hits += v.matched;
         idx_errors += v.index_error;
         pending.push_back(v);
      endfunction

      function void check(verdict_type got);
         verdict_type w;
         if (pending.size() == 0) begin
            $error("unexpected response");
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.matched != w.matched) begin
            $error("matched expected %0d got %0d", w.matched, got.matched);
            errors++;
         end
         if (got.rule_id != w.rule_id) begin
            $error("rule_id expected %0d got %0d", w.rule_id, got.rule_id);
            errors++;
         end
         if (got.index_error != w.index_error) begin
            $error("index_error expected %0d got %0d", w.index_error, got.index_error);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_mode = 0;
   logic [31:0] req_src_addr = 0, req_dst_addr = 0;
   logic [7:0] req_protocol = 0;
   logic [15:0] req_src_port = 0, req_dst_port = 0, req_table_index = 0;
   logic [3:0] req_table_select = 0;
   logic [12:0] req_table_data = 0;
   logic rsp_ready = 0;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   wire req_ready, rsp_valid, rsp_matched, rsp_index_error, csr_pready;
   wire [11:0] rsp_rule_id;
   wire [31:0] csr_prdata;

   rfc_packet_classify_lookup_top uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   rfc_scoreboard sb = new();
   int sent;
   bit bursty;
   bit [31:0] src_pool[6], dst_pool[6];
   bit [15:0] sport_pool[6], dport_pool[6];
   bit [7:0] proto_pool[6];

   task automatic send(request_type r);
      int gap;
      gap = bursty ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= r.mode;
      req_src_addr <= r.src;
      req_dst_addr <= r.dst;
      req_protocol <= r.proto;
      req_src_port <= r.sport;
      req_dst_port <= r.dport;
      req_table_select <= r.sel;
      req_table_index <= r.idx;
      req_table_data <= r.data;
      do @(posedge clock); while (!req_ready);
      sb.note(r);
      sent++;
   endtask

   function automatic request_type any_request();
      request_type r;
      r.mode = MODE_CLASSIFY;
      r.src = $urandom;
      r.dst = $urandom;
      r.proto = 8'($urandom);
      r.sport = 16'($urandom);
      r.dport = 16'($urandom);
      r.sel = 4'($urandom);
      r.idx = 16'($urandom);
      r.data = 13'($urandom);
      return r;
   endfunction

   task automatic put(int s, int i, int d);
      request_type r;
      r = any_request();
      r.mode = MODE_WRITE;
      r.sel = 4'(s);
      r.idx = 16'(i);
      r.data = 13'(d);
      send(r);
   endtask

   // loads every entry the lookup will touch, then sends it
   task automatic lookup(request_type r);
      verdict_type v;
      int d, k;
      r.mode = MODE_CLASSIFY;
      forever begin
         sb.classify(r, v);
         if (sb.miss_sel < 0) break;
         k = $urandom_range(0, 9);
         if (sb.miss_sel == rfc_pkg::SEL_FINAL)
            d = (k < 2) ? 0 : (k == 2) ? $urandom_range(4097, 8191) : $urandom_range(1, 4096);
         else
            d = (k < 8) ? $urandom_range(0, 3) : $urandom_range(0, 8191);
         put(sb.miss_sel, sb.miss_idx, d);
      end
      send(r);
   endtask

   task automatic csr_write(logic [2:0] r, int unsigned v);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      sb.set_reg(r, v);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(int phases, int lo, int hi);
      drain();
      csr_write(rfc_pkg::REG_NUM_PHASES, phases);
      for (int r = 1; r < 8; r++) csr_write(3'(r), $urandom_range(lo, hi));
   endtask

   task automatic run_random(int target);
      request_type r;
      int k;
      while (sent < target) begin
         r = any_request();
         k = $urandom_range(0, 9);
         if (k < 6) begin
            r.src = src_pool[$urandom_range(0, 5)];
            r.dst = dst_pool[$urandom_range(0, 5)];
            r.proto = proto_pool[$urandom_range(0, 5)];
            r.sport = sport_pool[$urandom_range(0, 5)];
            r.dport = dport_pool[$urandom_range(0, 5)];
         end
         if (k < 9) lookup(r);
         else begin
            r.mode = MODE_WRITE;
            send(r);
         end
      end
   endtask

   initial begin
      request_type r;
      for (int i = 0; i < 6; i++) begin
         src_pool[i] = (i == 0) ? 0 : (i == 1) ? '1 : $urandom;
         dst_pool[i] = (i == 0) ? 0 : (i == 1) ? '1 : $urandom;
         proto_pool[i] = (i == 0) ? 8'd0 : (i == 1) ? 8'hFF : 8'($urandom);
         sport_pool[i] = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : 16'($urandom);
         dport_pool[i] = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : 16'($urandom);
      end
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // all-zero and all-ones headers share one path with reset class counts
      for (int s = SEL_SRC_LO; s <= rfc_pkg::SEL_P3; s++) put(s, 0, 0);
      for (int s = SEL_SRC_LO; s <= SEL_DPORT; s++) put(s, s == SEL_PROTO ? 8'hFF : 16'hFFFF, 0);
      put(rfc_pkg::SEL_FINAL, 0, 0);
      r = any_request();
      r = '{MODE_CLASSIFY, 0, 0, 0, 0, 0, '1, '1, '1};
      lookup(r);
      put(rfc_pkg::SEL_FINAL, 0, 4097);
      r = '{MODE_CLASSIFY, '1, '1, '1, '1, '1, 0, 0, 0};
      lookup(r);
      put(rfc_pkg::SEL_FINAL, 0, 4096);
      lookup(r);
      put(rfc_pkg::SEL_FINAL, 0, 1);
      put(SEL_SRC_LO, 0, 4096);
      put(4'd13, 0, 5);
      put(4'd15, 16'hFFFF, 8191);
      put(rfc_pkg::SEL_FINAL, 4096, 3);
      put(SEL_PROTO, 300, 7);
      r.src = 0;
      lookup(r);

      bursty = 0;
      run_random(300);
      configure(3, 1, 4);
      run_random(550);
      bursty = 1;
      configure(4, 4096, 4096);
      run_random(750);
      bursty = 0;
      configure(3, 4096, 4096);
      run_random(950);
      configure(0, 0, 0);
      run_random(1100);
      configure(7, 1, 16);
      run_random(1300);
      configure(3, 1, 2);
      csr_write(rfc_pkg::REG_DST_PAIR, 4096);
      run_random(1550);
      drain();

      $display("%0d requests sent, %0d lookups: %0d matched, %0d index errors",
               sent, sb.lookups, sb.hits, sb.idx_errors);
      if (sb.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      verdict_type v;
      int gap;
      @(negedge reset);
      forever begin
         gap = bursty ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         v = '{rsp_matched, rsp_rule_id, rsp_index_error};
         sb.check(v);
      end
   end

   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- rfc_packet_classify_lookup_top.f -----
rtl/core/rfc_pkg.sv
rtl/core/rfc_ram.sv
rtl/core/rfc_front.sv
rtl/core/rfc_back.sv
rtl/core/rfc_packet_classify_lookup_top.sv
sim/tb_rfc_packet_classify_lookup_top.sv
